### sv/scat_pkg.sv
// ----------------------------------------------------------------------------
// scat_pkg
// Shared types and codes for the sorted card access table.
// ----------------------------------------------------------------------------
package scat_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_UPDATED  = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_ABSENT   = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_BADIDX   = 3'd6;

    localparam int ENTRY_W = 65;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // capture request
        logic srch_init;  // lo=0, hi=fill
        logic rd_mid;     // memory address = mid
        logic rd_rs;      // memory address = read_slot
        logic step;       // evaluate compare on read data
        logic upd_write;  // write new flag/time at pos
        logic ins_rd;     // read cursor-1 (shift up)
        logic ins_wr;     // write cursor with read data, step down
        logic ins_put;    // write new entry at pos, fill++
        logic rem_rd;     // read cursor+1
        logic rem_wr;     // write cursor with data, step up
        logic rem_done;   // fill--
        logic cap_entry;  // capture read data as reported entry
        logic emit;       // strobe result
        logic [2:0] status;
        logic zero_entry;
        logic zero_slot;
    } t_cmd;

    typedef struct packed {
        logic       srch_done;  // lo >= hi
        logic       hit;
        logic       full;
        logic       rs_ok;
        logic       ins_more;   // cursor > pos
        logic       rem_more;   // cursor+1 < fill
        t_op        op;
    } t_sts;

endpackage

### sv/scat_ram.sv
// ----------------------------------------------------------------------------
// scat_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module scat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### sv/scat_datapath.sv
// ----------------------------------------------------------------------------
// scat_datapath
// Request registers, search bounds, shift cursor, table memory and result.
// ----------------------------------------------------------------------------
module scat_datapath #(
    parameter int CAPACITY = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scat_pkg::t_cmd  i_cmd,
    output scat_pkg::t_sts  o_sts,
    input  logic [1:0]      i_op,
    input  logic [31:0]     i_card_id,
    input  logic            i_grant,
    input  logic [31:0]     i_stamp,
    input  logic [7:0]      i_read_slot,
    output logic            o_done,
    output logic [2:0]      o_status,
    output logic [7:0]      o_slot,
    output logic [31:0]     o_entry_id,
    output logic            o_entry_grant,
    output logic [31:0]     o_entry_stamp,
    output logic [8:0]      o_used
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [1:0]  r_op;
    logic [31:0] r_key, r_stamp;
    logic        r_grant;
    logic [7:0]  r_rs;
    logic [CW-1:0] r_fill, r_lo, r_hi, r_cur, r_pos;
    logic        r_hit;
    logic [CW-1:0] w_mid;
    logic [AW-1:0] w_addr;
    logic          w_we;
    logic [scat_pkg::ENTRY_W-1:0] w_wdata, w_rdata;
    logic [31:0]   w_rid;

    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign w_rid = w_rdata[64:33];

    always_comb begin
        w_we    = 1'b0;
        w_wdata = w_rdata;
        w_addr  = w_mid[AW-1:0];
        if (i_cmd.rd_rs) begin
            w_addr = CW'(r_rs) < CW'(CAPACITY) ? AW'(r_rs) : '0;
        end else if (i_cmd.upd_write || i_cmd.ins_put) begin
            w_addr  = r_pos[AW-1:0];
            w_we    = 1'b1;
            w_wdata = {r_key, r_grant, r_stamp};
        end else if (i_cmd.ins_rd) begin
            w_addr = AW'(r_cur - 1'b1);
        end else if (i_cmd.ins_wr || i_cmd.rem_wr) begin
            w_addr = r_cur[AW-1:0];
            w_we   = 1'b1;
        end else if (i_cmd.rem_rd) begin
            w_addr = AW'(r_cur + 1'b1);
        end
    end

    scat_ram #(.WIDTH(scat_pkg::ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.emit;
            if (i_cmd.ins_put)  r_fill <= r_fill + 1'b1;
            if (i_cmd.rem_done) r_fill <= r_fill - 1'b1;
        end
        if (i_cmd.load) begin
            r_op <= i_op; r_key <= i_card_id; r_grant <= i_grant;
            r_stamp <= i_stamp; r_rs <= i_read_slot;
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0; r_hi <= r_fill; r_hit <= 1'b0;
        end
        if (i_cmd.step) begin
            if (w_rid == r_key) begin
                // collapse both bounds onto the hit so mid keeps addressing it
                r_hit <= 1'b1; r_pos <= w_mid; r_lo <= w_mid; r_hi <= w_mid;
            end else if (r_key < w_rid) begin
                r_hi <= w_mid;
            end else begin
                r_lo <= w_mid + 1'b1;
            end
        end
        if (i_cmd.step && (r_lo >= r_hi)) r_pos <= r_lo;
        if (o_sts.srch_done && !r_hit && !i_cmd.step) r_pos <= r_lo;
        if (i_cmd.srch_init) r_cur <= r_fill;
        if (i_cmd.ins_wr) r_cur <= r_cur - 1'b1;
        if (i_cmd.rem_wr) r_cur <= r_cur + 1'b1;
        if (i_cmd.cap_entry) r_cur <= r_pos;
        if (i_cmd.cap_entry) begin
            o_entry_id <= w_rid; o_entry_grant <= w_rdata[32];
            o_entry_stamp <= w_rdata[31:0];
        end
        if (i_cmd.emit) begin
            o_status <= i_cmd.status;
            o_slot   <= i_cmd.zero_slot ? 8'd0 :
                        (r_op == scat_pkg::OP_READ) ? r_rs : 8'(r_pos);
            if (i_cmd.zero_entry) begin
                o_entry_id <= '0; o_entry_grant <= 1'b0; o_entry_stamp <= '0;
            end
            if (i_cmd.ins_put || i_cmd.upd_write) begin
                o_entry_id <= r_key; o_entry_grant <= r_grant; o_entry_stamp <= r_stamp;
            end
            o_used <= i_cmd.ins_put ? 9'(r_fill + 1'b1) :
                      i_cmd.rem_done ? 9'(r_fill - 1'b1) : 9'(r_fill);
        end
    end

    // emit bits derive from r_fill before update when combined with put/done
    assign o_sts.srch_done = r_lo >= r_hi;
    assign o_sts.hit       = r_hit;
    assign o_sts.full      = r_fill >= CW'(CAPACITY);
    assign o_sts.rs_ok     = 32'(r_rs) < 32'(r_fill);
    assign o_sts.ins_more  = r_cur > r_pos;
    assign o_sts.rem_more  = (r_cur + 1'b1) < r_fill;
    assign o_sts.op        = scat_pkg::t_op'(r_op);
endmodule

### sv/scat_ctrl.sv
// ----------------------------------------------------------------------------
// scat_ctrl
// Sequencer: search, update, shift up, shift down, report.
// ----------------------------------------------------------------------------
module scat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output scat_pkg::t_cmd  o_cmd,
    input  scat_pkg::t_sts  i_sts
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DISP  = 11'b00000000010,
        S_SRD   = 11'b00000000100,
        S_SCMP  = 11'b00000001000,
        S_DEC   = 11'b00000010000,
        S_ERD   = 11'b00000100000,
        S_ECAP  = 11'b00001000000,
        S_IRD   = 11'b00010000000,
        S_IWR   = 11'b00100000000,
        S_MRD   = 11'b01000000000,
        S_MWR   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.srch_init = 1'b1;
                n_state = (i_sts.op == scat_pkg::OP_READ) ? S_ERD : S_SRD;
            end
            S_SRD: begin
                if (i_sts.srch_done) n_state = S_DEC;
                else begin
                    o_cmd.rd_mid = 1'b1;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.step = 1'b1;   // hold address on mid for this compare
                n_state = S_SRD;
            end
            S_DEC: begin
                case (i_sts.op)
                    scat_pkg::OP_LOOKUP, scat_pkg::OP_REMOVE: begin
                        if (i_sts.hit) begin
                            n_state = S_ERD;
                        end else begin
                            o_cmd.emit = 1'b1; o_cmd.status = scat_pkg::ST_ABSENT;
                            o_cmd.zero_entry = 1'b1; o_cmd.zero_slot = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    scat_pkg::OP_INSERT: begin
                        if (i_sts.hit) begin
                            o_cmd.upd_write = 1'b1; o_cmd.emit = 1'b1;
                            o_cmd.status = scat_pkg::ST_UPDATED;
                            n_state = S_IDLE;
                        end else if (i_sts.full) begin
                            o_cmd.emit = 1'b1; o_cmd.status = scat_pkg::ST_FULL;
                            o_cmd.zero_entry = 1'b1; o_cmd.zero_slot = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_IRD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_ERD: begin
                if (i_sts.op == scat_pkg::OP_READ && !i_sts.rs_ok) begin
                    o_cmd.emit = 1'b1; o_cmd.status = scat_pkg::ST_BADIDX;
                    o_cmd.zero_entry = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_rs = (i_sts.op == scat_pkg::OP_READ);
                    n_state = S_ECAP;
                end
            end
            S_ECAP: begin
                o_cmd.cap_entry = 1'b1;  // also sets cursor = pos
                if (i_sts.op == scat_pkg::OP_READ) begin
                    o_cmd.emit = 1'b1; o_cmd.status = scat_pkg::ST_FOUND;
                    n_state = S_IDLE;
                end else if (i_sts.op == scat_pkg::OP_LOOKUP) begin
                    o_cmd.emit = 1'b1; o_cmd.status = scat_pkg::ST_FOUND;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_IRD: begin
                if (i_sts.ins_more) begin
                    o_cmd.ins_rd = 1'b1;
                    n_state = S_IWR;
                end else begin
                    o_cmd.ins_put = 1'b1; o_cmd.emit = 1'b1;
                    o_cmd.status = scat_pkg::ST_INSERTED;
                    n_state = S_IDLE;
                end
            end
            S_IWR: begin
                o_cmd.ins_wr = 1'b1;
                n_state = S_IRD;
            end
            S_MRD: begin
                if (i_sts.rem_more) begin
                    o_cmd.rem_rd = 1'b1;
                    n_state = S_MWR;
                end else begin
                    o_cmd.rem_done = 1'b1; o_cmd.emit = 1'b1;
                    o_cmd.status = scat_pkg::ST_REMOVED;
                    n_state = S_IDLE;
                end
            end
            S_MWR: begin
                o_cmd.rem_wr = 1'b1;
                n_state = S_MRD;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### sv/sorted_card_access_table.sv
// ----------------------------------------------------------------------------
// sorted_card_access_table
// Sorted card table with binary search, insert, update, remove and read.
// ----------------------------------------------------------------------------
// Every request but read runs a binary search of at most log2(used+1) steps,
// rounded up; insert and remove then shift the entries above the slot one by one.
// One request at a time; busy is high from accept until the result strobe.
// Synchronous active-low reset empties the table; entries need no clearing.
// The result is shown for one cycle with o_done; the receiver cannot stall.
module sorted_card_access_table #(
    parameter int CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_card_id,
    input  logic        i_grant,
    input  logic [31:0] i_stamp,
    input  logic [7:0]  i_read_slot,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [7:0]  o_slot,
    output logic [31:0] o_entry_id,
    output logic        o_entry_grant,
    output logic [31:0] o_entry_stamp,
    output logic [8:0]  o_used
);
    scat_pkg::t_cmd w_cmd;
    scat_pkg::t_sts w_sts;

    scat_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    scat_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_op(i_op), .i_card_id(i_card_id), .i_grant(i_grant),
        .i_stamp(i_stamp), .i_read_slot(i_read_slot),
        .o_done(o_done), .o_status(o_status), .o_slot(o_slot),
        .o_entry_id(o_entry_id), .o_entry_grant(o_entry_grant),
        .o_entry_stamp(o_entry_stamp), .o_used(o_used)
    );
endmodule

### tb/sv/sorted_card_access_table_tb.sv
// ----------------------------------------------------------------------------
// sorted_card_access_table_tb
// Self-checking regression for the sorted card table: directed corner cases
// (empty table, full table, key extremes, bad indexes) followed by random
// request streams, each result compared against a behavioral table model.
// ----------------------------------------------------------------------------
module sorted_card_access_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  slot;
        logic [31:0] entry_id;
        logic        entry_grant;
        logic [31:0] entry_stamp;
        logic [8:0]  used;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [31:0] i_card_id;
    logic        i_grant;
    logic [31:0] i_stamp;
    logic [7:0]  i_read_slot;
    logic        o_done;
    logic [2:0]  o_status;
    logic [7:0]  o_slot;
    logic [31:0] o_entry_id;
    logic        o_entry_grant;
    logic [31:0] o_entry_stamp;
    logic [8:0]  o_used;

    sorted_card_access_table #(.CAPACITY(CAP)) dut (.*);

    // table model
    logic [31:0] card_ids [CAP];
    logic        card_grants [CAP];
    logic [31:0] card_stamps [CAP];
    int unsigned card_count;

    t_outcome pending_outcomes [$];
    int  error_count = 0;
    int  request_count = 0;
    int  result_count = 0;
    int  idle_cycles = 0;
    bit  idle_free = 0;
    int  op_hits [4] = '{default: 0};

    initial begin
        i_clk = 0;
    end
    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    function automatic bit search_card(input logic [31:0] key, output int unsigned pos);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = card_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (card_ids[mid] == key) begin
                pos = mid;
                return 1;
            end
            if (key < card_ids[mid]) hi = mid;
            else lo = mid + 1;
        end
        pos = lo;
        return 0;
    endfunction

    function automatic t_outcome make_outcome(input logic [2:0] st, input int unsigned pos,
                                              input bit with_entry);
        t_outcome r;
        r.status = st;
        r.slot = pos[7:0];
        if (with_entry && pos < card_count) begin
            r.entry_id = card_ids[pos];
            r.entry_grant = card_grants[pos];
            r.entry_stamp = card_stamps[pos];
        end else begin
            r.entry_id = '0;
            r.entry_grant = 1'b0;
            r.entry_stamp = '0;
        end
        r.used = card_count[8:0];
        return r;
    endfunction

    function automatic t_outcome apply_request(input scat_pkg::t_op op,
                                               input logic [31:0] key,
                                               input logic flag, input logic [31:0] now,
                                               input logic [7:0] rs);
        int unsigned pos;
        bit hit;
        t_outcome r;
        pos = 0;
        if (op == scat_pkg::OP_READ) begin
            if (rs < card_count) return make_outcome(scat_pkg::ST_FOUND, rs, 1);
            return make_outcome(scat_pkg::ST_BADIDX, rs, 0);
        end
        hit = search_card(key, pos);
        case (op)
            scat_pkg::OP_LOOKUP: begin
                if (hit) return make_outcome(scat_pkg::ST_FOUND, pos, 1);
                return make_outcome(scat_pkg::ST_ABSENT, 0, 0);
            end
            scat_pkg::OP_INSERT: begin
                if (hit) begin
                    card_grants[pos] = flag;
                    card_stamps[pos] = now;
                    return make_outcome(scat_pkg::ST_UPDATED, pos, 1);
                end
                if (card_count >= CAP) return make_outcome(scat_pkg::ST_FULL, 0, 0);
                for (int unsigned i = card_count; i > pos; i--) begin
                    card_ids[i] = card_ids[i-1];
                    card_grants[i] = card_grants[i-1];
                    card_stamps[i] = card_stamps[i-1];
                end
                card_ids[pos] = key;
                card_grants[pos] = flag;
                card_stamps[pos] = now;
                card_count++;
                return make_outcome(scat_pkg::ST_INSERTED, pos, 1);
            end
            default: begin
                if (!hit) return make_outcome(scat_pkg::ST_ABSENT, 0, 0);
                r = make_outcome(scat_pkg::ST_REMOVED, pos, 1);
                for (int unsigned i = pos; i + 1 < card_count; i++) begin
                    card_ids[i] = card_ids[i+1];
                    card_grants[i] = card_grants[i+1];
                    card_stamps[i] = card_stamps[i+1];
                end
                card_count--;
                r.used = card_count[8:0];
                return r;
            end
        endcase
    endfunction

    task automatic send_request(input scat_pkg::t_op op, input logic [31:0] key,
                                input logic flag, input logic [31:0] now,
                                input logic [7:0] rs);
        // random idle gaps before the request
        while (!idle_free && $urandom_range(99) < 28) @(posedge i_clk);
        start       <= 1'b1;
        i_op        <= op;
        i_card_id   <= key;
        i_grant     <= flag;
        i_stamp     <= now;
        i_read_slot <= rs;
        // busy only moves at the rising edge, so the falling edge shows what it will see
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        // accepted at this edge
        pending_outcomes.push_back(apply_request(op, key, flag, now, rs));
        request_count++;
        op_hits[op]++;
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_outcome e;
            result_count++;
            if (pending_outcomes.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                e = pending_outcomes.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); error_count++;
                end
                if (o_slot !== e.slot) begin
                    $error("slot exp %0d got %0d", e.slot, o_slot); error_count++;
                end
                if (o_entry_id !== e.entry_id) begin
                    $error("entry_id exp %h got %h", e.entry_id, o_entry_id); error_count++;
                end
                if (o_entry_grant !== e.entry_grant) begin
                    $error("entry_grant exp %0d got %0d", e.entry_grant, o_entry_grant);
                    error_count++;
                end
                if (o_entry_stamp !== e.entry_stamp) begin
                    $error("entry_stamp exp %h got %h", e.entry_stamp, o_entry_stamp);
                    error_count++;
                end
                if (o_used !== e.used) begin
                    $error("used exp %0d got %0d", e.used, o_used); error_count++;
                end
            end
        end
    end

    // watchdog: cycles with neither a request accepted nor a result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_card_access_table regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] pick_present_or_random();
        if (card_count != 0 && $urandom_range(99) < 70)
            return card_ids[$urandom_range(card_count - 1)];
        return $urandom();
    endfunction

    task automatic test_empty_table();
        send_request(scat_pkg::OP_LOOKUP, 32'h0, 1'b0, 32'h0, 8'd0);
        send_request(scat_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b0, 32'h0, 8'd0);
        send_request(scat_pkg::OP_READ, 32'h0, 1'b0, 32'h0, 8'd0);
        send_request(scat_pkg::OP_READ, 32'h0, 1'b0, 32'h0, 8'hFF);
    endtask

    task automatic test_key_extremes();
        send_request(scat_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'd0);
        send_request(scat_pkg::OP_INSERT, 32'h0, 1'b0, 32'h0, 8'd0);
        send_request(scat_pkg::OP_INSERT, 32'h8000_0000, 1'b1, 32'h1234_5678, 8'd0);
        send_request(scat_pkg::OP_INSERT, 32'h0, 1'b1, 32'hFFFF_FFFF, 8'd0);      // update
        send_request(scat_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'h0, 8'd0);
        send_request(scat_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 1'b0, 32'h0, 8'd0);
        send_request(scat_pkg::OP_READ, 32'h0, 1'b0, 32'h0, 8'd1);
        send_request(scat_pkg::OP_READ, 32'h0, 1'b0, 32'h0, 8'd3);            // bad index
        send_request(scat_pkg::OP_REMOVE, 32'h8000_0000, 1'b0, 32'h0, 8'd0);
        send_request(scat_pkg::OP_REMOVE, 32'h8000_0000, 1'b0, 32'h0, 8'd0);  // absent now
        send_request(scat_pkg::OP_REMOVE, 32'h0, 1'b0, 32'h0, 8'd0);
        send_request(scat_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b0, 32'h0, 8'd0);
        drain_results();
    endtask

    task automatic test_full_table();
        // fill to capacity with no idling, then probe the full condition
        idle_free = 1;
        while (card_count < CAP)
            send_request(scat_pkg::OP_INSERT, $urandom(), $urandom_range(1), $urandom(),
                         8'd0);
        idle_free = 0;
        send_request(scat_pkg::OP_INSERT, ~card_ids[0] ^ 32'h1, 1'b1, 32'h5, 8'd0);
        send_request(scat_pkg::OP_INSERT, card_ids[CAP-1], 1'b0, 32'hA5A5_A5A5, 8'd0);
        send_request(scat_pkg::OP_READ, 32'h0, 1'b0, 32'h0, 8'hFF);
        send_request(scat_pkg::OP_READ, 32'h0, 1'b0, 32'h0, 8'd0);
        send_request(scat_pkg::OP_LOOKUP, card_ids[CAP/2], 1'b0, 32'h0, 8'd0);
        drain_results();
        while (card_count > 200)
            send_request(scat_pkg::OP_REMOVE, card_ids[$urandom_range(card_count - 1)], 1'b0,
                         32'h0, 8'd0);
        drain_results();
    endtask

    task automatic test_random_traffic(input int n);
        scat_pkg::t_op op;
        for (int k = 0; k < n; k++) begin
            op = scat_pkg::t_op'($urandom_range(3));
            // keep the table mid-sized so shifts stay short but nontrivial
            if (card_count > 48 && op == scat_pkg::OP_INSERT && $urandom_range(1))
                op = scat_pkg::OP_REMOVE;
            if (card_count < 4 && op == scat_pkg::OP_REMOVE) op = scat_pkg::OP_INSERT;
            send_request(op, pick_present_or_random(), $urandom_range(1), $urandom(),
                         $urandom_range(255) < 200 ? 8'($urandom_range(card_count + 2))
                                                   : 8'($urandom_range(255)));
            if (k == n / 2) drain_results();
        end
    endtask

    initial begin
        start = 0;
        i_op = scat_pkg::OP_LOOKUP;
        i_card_id = '0;
        i_grant = 0;
        i_stamp = '0;
        i_read_slot = '0;
        i_rst_n = 0;
        card_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_empty_table();
        test_key_extremes();
        test_full_table();
        test_random_traffic(120);
        drain_results();
        repeat (50) @(posedge i_clk);
        $display("covered %0d requests (lookup %0d, insert %0d, remove %0d, read %0d),",
                 request_count, op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
        $display("%0d results checked, including a full table and key extremes", result_count);
        if (error_count == 0 && pending_outcomes.size() == 0)
            $display("sorted_card_access_table regression: pass");
        else
            $display("sorted_card_access_table regression: fail");
        $finish;
    end
endmodule

### files.f
sv/scat_pkg.sv
sv/scat_ram.sv
sv/scat_datapath.sv
sv/scat_ctrl.sv
sv/sorted_card_access_table.sv
tb/sv/sorted_card_access_table_tb.sv
